FILE: design/memory_hard_block_mixer_unit_defines.svh
// Assertion macros shared by the mixer RTL.
// Used by memory_hard_block_mixer_unit.sv; expects clk and rst in scope.
`ifndef MEMORY_HARD_BLOCK_MIXER_UNIT_DEFINES_SVH
`define MEMORY_HARD_BLOCK_MIXER_UNIT_DEFINES_SVH

// same-cycle implication
`define MHBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MHBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/mhbm_pkg.sv
// Types and constants for the memory-hard block mixer.
// No dependencies; used by memory_hard_block_mixer_unit.sv and mhbm_mul.sv.
`timescale 1ns / 1ps
`default_nettype none

package mhbm_pkg;

  localparam int WORD_W  = 32;
  localparam int CHAIN_W = 64;
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 3;
  localparam int CFG_W   = 4;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MIX  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_CHAIN_MULT = 3'd0;
  localparam logic [CFG_W-1:0]  CHAIN_MULT_RESET = 4'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAIN_MUL,
    ST_CHAIN_MIX,
    ST_MIX,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

FILE: design/memory_hard_block_mixer_unit.sv
// Top level of the memory-hard block mixer: state words, chain sequencer,
// output register and APB configuration. Depends on mhbm_pkg, mhbm_mul
// and memory_hard_block_mixer_unit_defines.svh.
//
// Usage:
//   Input channel in_valid/in_stall carries one request: kind 0 loads a
//   state word, kind 1 mixes one word, kind 2 reads out all eight words.
//   Output channel out_valid/out_stall carries out_word, chain_out, last.
//   A load gives no result. A mix gives one result; at word position 0 it
//   first runs min(chain_multiplies, 8) chain steps through one shared
//   multiplier (multiply, then xor/add). A read gives eight results, one
//   per cycle while out_stall is low. in_stall is high while a request is
//   in progress. A result waits in the output register while out_stall is
//   high; the sequencer holds until the register frees and takes no new
//   request meanwhile.
//   chain_multiplies sits at byte address 0 of the APB port, reset value 2.
//   Reset clears the state words to 0, multipliers to 1, chain value to 1,
//   random word and position to 0, and empties the output register.
`include "memory_hard_block_mixer_unit_defines.svh"
`timescale 1ns / 1ps
`default_nettype none

module memory_hard_block_mixer_unit #(
  parameter int STATE_WORDS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mhbm_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [mhbm_pkg::KIND_W-1:0]       kind,
  input  wire logic [$clog2(STATE_WORDS)-1:0]    word_index,
  input  wire logic [mhbm_pkg::WORD_W-1:0]       load_value,
  input  wire logic [mhbm_pkg::WORD_W-1:0]       from_word,
  input  wire logic [mhbm_pkg::WORD_W-1:0]       prev_word,
  input  wire logic                              subblock_start,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [mhbm_pkg::WORD_W-1:0]       out_word,
  output logic      [mhbm_pkg::CHAIN_W-1:0]      chain_out,
  output logic                                   last
);

  localparam int IDX_W = $clog2(STATE_WORDS);
  localparam int CNT_W = $clog2(STATE_WORDS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

  mhbm_pkg::state_t state, state_next;

  logic [mhbm_pkg::WORD_W-1:0]  hash_state [STATE_WORDS];
  logic [mhbm_pkg::WORD_W-1:0]  odd_mult   [STATE_WORDS];
  logic [mhbm_pkg::CHAIN_W-1:0] chain;
  logic [mhbm_pkg::WORD_W-1:0]  rand_word;
  logic [IDX_W-1:0]             pos;
  logic [CNT_W-1:0]             step_cnt;
  logic [mhbm_pkg::CFG_W-1:0]   chain_mult;
  logic [mhbm_pkg::WORD_W-1:0]  from_q;
  logic [mhbm_pkg::WORD_W-1:0]  prev_q;

  logic                         in_accept;
  logic                         out_free;
  logic                         cfg_write;
  logic [CNT_W-1:0]             steps;
  logic [IDX_W-1:0]             rd_idx;
  logic [mhbm_pkg::WORD_W-1:0]  rd_word;
  logic [mhbm_pkg::WORD_W-1:0]  mix_sum;
  logic [mhbm_pkg::WORD_W-1:0]  mix_word;
  logic [mhbm_pkg::CHAIN_W-1:0] product;
  logic                         mul_en;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == mhbm_pkg::ADDR_CHAIN_MULT) ? 32'(chain_mult) : 32'd0;

  assign in_stall  = (state != mhbm_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign steps    = (chain_mult > mhbm_pkg::CFG_W'(STATE_WORDS))
                    ? CNT_W'(STATE_WORDS) : CNT_W'(chain_mult);
  assign rd_idx   = (state == mhbm_pkg::ST_READ) ? step_cnt[IDX_W-1:0] : pos;
  assign rd_word  = hash_state[rd_idx];
  assign mix_sum  = (rd_word + prev_q) ^ from_q;
  assign mix_word = {mix_sum[mhbm_pkg::WORD_W-9:0], mix_sum[mhbm_pkg::WORD_W-1:mhbm_pkg::WORD_W-8]};
  assign mul_en   = (state == mhbm_pkg::ST_CHAIN_MUL);

  mhbm_mul u_mul (
    .clk     (clk),
    .en      (mul_en),
    .a       (chain[mhbm_pkg::WORD_W-1:0]),
    .b       (odd_mult[step_cnt[IDX_W-1:0]]),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhbm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mhbm_pkg::ST_IDLE: begin
        if (in_accept && kind == mhbm_pkg::KIND_MIX) begin
          if (pos == '0 && steps != '0) begin
            state_next = mhbm_pkg::ST_CHAIN_MUL;
          end else begin
            state_next = mhbm_pkg::ST_MIX;
          end
        end else if (in_accept && kind == mhbm_pkg::KIND_READ) begin
          state_next = mhbm_pkg::ST_READ;
        end
      end
      mhbm_pkg::ST_CHAIN_MUL: state_next = mhbm_pkg::ST_CHAIN_MIX;
      mhbm_pkg::ST_CHAIN_MIX: begin
        if (step_cnt + CNT_W'(1) == steps) begin
          state_next = mhbm_pkg::ST_MIX;
        end else begin
          state_next = mhbm_pkg::ST_CHAIN_MUL;
        end
      end
      mhbm_pkg::ST_MIX: begin
        if (out_free) begin
          state_next = mhbm_pkg::ST_IDLE;
        end
      end
      mhbm_pkg::ST_READ: begin
        if (out_free && step_cnt[IDX_W-1:0] == LAST_IDX) begin
          state_next = mhbm_pkg::ST_IDLE;
        end
      end
      default: state_next = mhbm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_mult <= mhbm_pkg::CHAIN_MULT_RESET;
    end else if (cfg_write && paddr == mhbm_pkg::ADDR_CHAIN_MULT) begin
      chain_mult <= pwdata[mhbm_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STATE_WORDS; i++) begin
        hash_state[i] <= '0;
        odd_mult[i]   <= mhbm_pkg::WORD_W'(1);
      end
      chain     <= mhbm_pkg::CHAIN_W'(1);
      rand_word <= '0;
      pos       <= '0;
      step_cnt  <= '0;
    end else begin
      case (state)
        mhbm_pkg::ST_IDLE: begin
          step_cnt <= '0;
          if (in_accept && kind == mhbm_pkg::KIND_LOAD) begin
            hash_state[word_index] <= load_value;
            odd_mult[word_index]   <= load_value | mhbm_pkg::WORD_W'(1);
            if (word_index == '0) begin
              chain <= mhbm_pkg::CHAIN_W'(1);
              pos   <= '0;
            end
          end else if (in_accept && kind == mhbm_pkg::KIND_MIX) begin
            if (subblock_start) begin
              rand_word <= from_word;
            end
          end
        end
        mhbm_pkg::ST_CHAIN_MIX: begin
          chain     <= product ^ mhbm_pkg::CHAIN_W'(rand_word);
          rand_word <= rand_word + product[mhbm_pkg::CHAIN_W-1:mhbm_pkg::WORD_W];
          step_cnt  <= step_cnt + CNT_W'(1);
        end
        mhbm_pkg::ST_MIX: begin
          if (out_free) begin
            hash_state[pos] <= mix_word;
            pos             <= (pos == LAST_IDX) ? '0 : pos + IDX_W'(1);
          end
        end
        mhbm_pkg::ST_READ: begin
          if (out_free) begin
            step_cnt <= step_cnt + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && kind == mhbm_pkg::KIND_MIX) begin
      from_q <= from_word;
      prev_q <= prev_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mhbm_pkg::ST_MIX && out_free) begin
      out_valid <= 1'b1;
    end else if (state == mhbm_pkg::ST_READ && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mhbm_pkg::ST_MIX && out_free) begin
      out_word  <= mix_word;
      chain_out <= chain;
      last      <= 1'b1;
    end else if (state == mhbm_pkg::ST_READ && out_free) begin
      out_word  <= rd_word;
      chain_out <= chain;
      last      <= (step_cnt[IDX_W-1:0] == LAST_IDX);
    end
  end

  `MHBM_ASSERT_NOW(a_chain_bound, state == mhbm_pkg::ST_CHAIN_MUL, step_cnt < steps, "chain step beyond limit")
  `MHBM_ASSERT_NEXT(a_mul_then_mix, state == mhbm_pkg::ST_CHAIN_MUL, state == mhbm_pkg::ST_CHAIN_MIX, "multiply not followed by chain update")
  `MHBM_ASSERT_NEXT(a_mix_no_chain, in_accept && kind == mhbm_pkg::KIND_MIX && pos != '0, state == mhbm_pkg::ST_MIX, "chain ran off group boundary")
  `MHBM_ASSERT_NEXT(a_read_last, state == mhbm_pkg::ST_READ && out_free && step_cnt[IDX_W-1:0] == LAST_IDX, out_valid && last && state == mhbm_pkg::ST_IDLE, "read-out did not end with last")

endmodule

`default_nettype wire

FILE: design/mhbm_mul.sv
// Shared 32x32 multiplier with a registered 64-bit product.
// Depends on mhbm_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module mhbm_mul (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [mhbm_pkg::WORD_W-1:0]   a,
  input  wire logic [mhbm_pkg::WORD_W-1:0]   b,
  output logic      [mhbm_pkg::CHAIN_W-1:0]  product
);

  always_ff @(posedge clk) begin
    if (en) begin
      product <= mhbm_pkg::CHAIN_W'(a) * mhbm_pkg::CHAIN_W'(b);
    end
  end

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for memory_hard_block_mixer_unit: load, mix and read-out requests,
// directed then random, checked against an in-bench model of the state and chain.
// Depends on mhbm_pkg and the mixer RTL only.

module testbench;

  localparam logic [mhbm_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int NWORDS = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 32;

  typedef logic [mhbm_pkg::WORD_W-1:0] word_t;
  typedef logic [mhbm_pkg::CHAIN_W-1:0] chain_t;

  typedef struct packed {
    logic [mhbm_pkg::KIND_W-1:0] kind;
    logic [2:0] word_index;
    word_t load_value;
    word_t from_word;
    word_t prev_word;
    logic subblock_start;
  } mix_req_t;

  typedef struct packed {
    word_t word;
    chain_t chain;
    logic last;
  } mix_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mhbm_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [mhbm_pkg::KIND_W-1:0] kind = mhbm_pkg::KIND_LOAD;
  logic [2:0] word_index = '0;
  word_t load_value = '0;
  word_t from_word = '0;
  word_t prev_word = '0;
  logic subblock_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  word_t out_word;
  chain_t chain_out;
  logic last;

  // model of the block
  word_t mixer_words [NWORDS];
  word_t odd_mults [NWORDS];
  chain_t chain_val;
  word_t random_val;
  logic [2:0] word_pos;
  logic [mhbm_pkg::CFG_W-1:0] chain_steps_cfg;

  mix_req_t pending_reqs [$];
  mix_out_t expected_words [$];
  mix_req_t on_wire;
  mix_out_t seen_word;
  mix_out_t want_word;

  int queued_items = 0;
  int mismatches = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycle = 0;
  int run_cycles = 0;

  memory_hard_block_mixer_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .word_index(word_index), .load_value(load_value),
    .from_word(from_word), .prev_word(prev_word), .subblock_start(subblock_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word), .chain_out(chain_out), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // advance the model by one accepted request and queue its results
  task automatic absorb_request(input mix_req_t r);
    logic [2:0] pos;
    int steps;
    case (r.kind)
      mhbm_pkg::KIND_LOAD: begin
        mixer_words[r.word_index] = r.load_value;
        odd_mults[r.word_index] = r.load_value | 32'd1;
        if (r.word_index == 3'd0) begin
          chain_val = 64'd1;
          word_pos = 3'd0;
        end
      end
      mhbm_pkg::KIND_MIX: begin
        pos = word_pos;
        if (r.subblock_start)
          random_val = r.from_word;
        if (pos == 3'd0) begin
          steps = (chain_steps_cfg > 4'd8) ? 8 : int'(chain_steps_cfg);
          for (int k = 0; k < steps; k++) begin
            chain_val = {32'd0, chain_val[31:0]} * {32'd0, odd_mults[k]};
            chain_val = chain_val ^ {32'd0, random_val};
            random_val = random_val + chain_val[63:32];
          end
        end
        mixer_words[pos] = (mixer_words[pos] + r.prev_word) ^ r.from_word;
        mixer_words[pos] = {mixer_words[pos][23:0], mixer_words[pos][31:24]};
        word_pos = pos + 3'd1;
        expected_words.push_back(mix_out_t'{mixer_words[pos], chain_val, 1'b1});
      end
      mhbm_pkg::KIND_READ: begin
        for (int k = 0; k < NWORDS; k++)
          expected_words.push_back(mix_out_t'{mixer_words[k], chain_val, k == NWORDS - 1});
      end
      default: begin
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input mix_out_t want, input mix_out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: expected word %h chain %h last %b, got word %h chain %h last %b",
               $time, what, want.word, want.chain, want.last, got.word, got.chain, got.last);
  endtask

  task automatic push_load(input logic [2:0] idx, input word_t val);
    pending_reqs.push_back(mix_req_t'{mhbm_pkg::KIND_LOAD, idx, val, $urandom(), $urandom(),
                                      1'b0});
    queued_items++;
  endtask

  task automatic push_mix(input word_t from_val, input word_t prev_val, input logic start);
    pending_reqs.push_back(mix_req_t'{mhbm_pkg::KIND_MIX, 3'($urandom_range(0, 7)), $urandom(),
                                      from_val, prev_val, start});
    queued_items++;
  endtask

  task automatic push_read();
    pending_reqs.push_back(mix_req_t'{mhbm_pkg::KIND_READ, 3'($urandom_range(0, 7)), $urandom(),
                                      $urandom(), $urandom(), 1'($urandom_range(0, 1))});
    queued_items++;
  endtask

  task automatic queue_random_phase(input int n);
    int stop_at;
    mix_req_t r;
    stop_at = queued_items + n;
    while (queued_items < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(0, 2) != 0)
            for (int i = 0; i < NWORDS; i++)
              push_load(3'(i), $urandom());
          repeat ($urandom_range(1, 2))
            for (int i = 0; i < NWORDS; i++)
              push_mix($urandom(), $urandom(), i == 0 || $urandom_range(0, 15) == 0);
          if ($urandom_range(0, 1) != 0)
            push_read();
        end
        6, 7: push_read();
        8: begin
          r.kind = mhbm_pkg::KIND_W'($urandom_range(0, 3));
          r.word_index = 3'($urandom_range(0, 7));
          r.load_value = $urandom();
          r.from_word = $urandom();
          r.prev_word = $urandom();
          r.subblock_start = 1'($urandom_range(0, 1));
          pending_reqs.push_back(r);
          if (r.kind != KIND_SPARE)
            queued_items++;
        end
        default: begin
          repeat ($urandom_range(1, 5))
            push_mix($urandom(), $urandom(), 1'($urandom_range(0, 1)));
        end
      endcase
    end
  endtask

  // hold until every request is taken and every result has come out
  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_chain_steps(input logic [mhbm_pkg::CFG_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= mhbm_pkg::ADDR_CHAIN_MULT;
    pwdata <= {28'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    chain_steps_cfg = v;
  endtask

  initial begin
    logic [mhbm_pkg::CFG_W-1:0] phase_cfg [7];
    phase_cfg = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd5, 4'd2, 4'd0};
    for (int i = 0; i < NWORDS; i++) begin
      mixer_words[i] = '0;
      odd_mults[i] = 32'd1;
    end
    chain_val = 64'd1;
    random_val = '0;
    word_pos = '0;
    chain_steps_cfg = mhbm_pkg::CHAIN_MULT_RESET;

    wait (!rst);
    @(negedge clk);

    // directed: reset state, extreme values, off-boundary start, spare kind
    push_read();
    push_load(3'd0, 32'hFFFF_FFFF);
    push_load(3'd7, 32'h0000_0000);
    push_load(3'd4, 32'h8000_0000);
    push_load(3'd1, 32'hFFFF_FFFE);
    push_mix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_mix(32'h0000_0000, 32'h0000_0000, 1'b1);
    for (int i = 0; i < 6; i++)
      push_mix($urandom(), $urandom(), 1'b0);
    push_mix(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    pending_reqs.push_back(mix_req_t'{KIND_SPARE, 3'd7, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    push_read();
    wait_idle();

    // register above eight runs eight steps
    write_chain_steps(4'hF);
    push_load(3'd0, 32'hFFFF_FFFE);
    push_mix(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    push_read();
    wait_idle();

    write_chain_steps(4'd0);
    push_load(3'd0, 32'h0000_0001);
    push_mix(32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1);
    push_read();
    wait_idle();

    foreach (phase_cfg[p]) begin
      write_chain_steps(phase_cfg[p]);
      if (phase_cfg[p] == 4'd8)
        hold_requests++;
      queue_random_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("memory_hard_block_mixer_unit verification clean");
    end else begin
      $display("memory_hard_block_mixer_unit verification failed");
    end
    $finish;
  end

  // request driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        absorb_request(on_wire);
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        on_wire = pending_reqs.pop_front();
        kind <= on_wire.kind;
        word_index <= on_wire.word_index;
        load_value <= on_wire.load_value;
        from_word <= on_wire.from_word;
        prev_word <= on_wire.prev_word;
        subblock_start <= on_wire.subblock_start;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with an occasional long hold
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (hold_seen != hold_requests) begin
        hold_seen <= hold_requests;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (stall_cycle[8:6])
          3'd0, 3'd1: out_stall <= 1'b0;
          3'd2: out_stall <= 1'($urandom_range(0, 1));
          3'd3: out_stall <= (stall_cycle[1:0] == 2'd0);
          3'd4: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_word = mix_out_t'{out_word, chain_out, last};
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected result", '0, seen_word);
      end else begin
        want_word = expected_words.pop_front();
        if (seen_word.word !== want_word.word || seen_word.chain !== want_word.chain ||
            seen_word.last !== want_word.last)
          note_mismatch("result mismatch", want_word, seen_word);
      end
    end
  end

  always @(posedge clk) begin
    run_cycles <= run_cycles + 1;
    if (run_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", run_cycles);
      $display("memory_hard_block_mixer_unit verification failed");
      $finish;
    end
  end

endmodule
